@@ design/oocp_pkg.sv @@
// Package for the operation overlap cycle profiler: types, codes and constants.
package oocp_pkg;

  localparam int unsigned DefMaxOps     = 8;
  localparam int unsigned DefMaxRecords = 16;
  localparam int unsigned KindCount     = 6;
  localparam logic [31:0] AllOnes       = 32'hFFFF_FFFF;
  localparam logic [7:0]  NoSlot        = 8'd255;

  typedef enum logic [2:0] {
    CmdStartOp    = 3'd0,
    CmdCompleteOp = 3'd1,
    CmdCancelOp   = 3'd2,
    CmdStartCyc   = 3'd3,
    CmdCompleteCyc = 3'd4,
    CmdScan       = 3'd5,
    CmdClear      = 3'd6,
    CmdRead       = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    RunIdle   = 2'd0,
    RunActive = 2'd1,
    RunDone   = 2'd2,
    RunCancel = 2'd3
  } run_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StScan,
    StCatSum,
    StFinish,
    StCount,
    StOut
  } state_e;

  function automatic logic pair_allowed(logic [2:0] a, logic [2:0] b);
    logic [2:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (lo == 3'd0 && hi == 3'd1) || (lo == 3'd4 && hi == 3'd5) ||
           (lo == 3'd0 && hi == 3'd5);
  endfunction

endpackage

@@ design/op_overlap_cycle_profiler_unit.sv @@
// Top level of the operation overlap cycle profiler.
//
// One command enters on the input channel (command_i and its operands,
// valid_i/ready_o); one result leaves on the output channel (valid_o/ready_i).
// Commands are taken one at a time: ready_o is high only while the sequencer
// is idle and no result is pending.
// The steps, with U the slots in use (at most MAX_OPS): an execute step,
// then a walk over the U used slots with a shared compare/add unit to count
// running slots, then an output step. An overlap scan first walks slot pairs
// i<j, one per cycle; an accepted complete cycle adds the six category sums
// one per cycle and then closes the cycle record before the walk.
// The next command is taken only once the sequencer is back in idle after
// the result leaves, so a new command waits until the last is through.
// The result is held in an output register until ready_i is seen; the block
// takes no new command while it waits.
// Reset (and the clear command) returns all counters to zero, best to all
// ones. Ring entries need no clearing: a read beyond the fill count returns
// zeros.
module op_overlap_cycle_profiler_unit #(
  parameter int unsigned MAX_OPS     = oocp_pkg::DefMaxOps,
  parameter int unsigned MAX_RECORDS = oocp_pkg::DefMaxRecords
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [2:0]  command_i,
  input  logic [2:0]  op_kind_i,
  input  logic [7:0]  slot_select_i,
  input  logic [15:0] cycle_label_i,
  input  logic [7:0]  record_select_i,
  input  logic [31:0] now_ms_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        ok_o,
  output logic [7:0]  slot_given_o,
  output logic [15:0] record_cycle_label_o,
  output logic [31:0] record_total_ms_o,
  output logic [31:0] record_saved_ms_o,
  output logic [6:0]  running_count_o,
  output logic [6:0]  record_count_o,
  output logic [15:0] cycles_done_o,
  output logic [31:0] overlap_total_ms_o,
  output logic [31:0] best_ms_o,
  output logic [31:0] worst_ms_o,
  output logic [31:0] cycle_sum_ms_o
);
  import oocp_pkg::*;

  localparam int unsigned SW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
  localparam int unsigned UW = $clog2(MAX_OPS + 1);
  localparam int unsigned RW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned FW = $clog2(MAX_RECORDS + 1);

  state_e state_q, state_d;

  logic [2:0]  kind_q [MAX_OPS];
  run_e        run_q  [MAX_OPS];
  logic [31:0] start_q [MAX_OPS];
  logic        mark_q [MAX_OPS];
  logic [UW-1:0] used_q;
  logic [31:0] cat_q [KindCount];
  logic [31:0] saved_q;
  logic [15:0] cur_label_q;
  logic        open_q;
  logic [RW-1:0] wpos_q;
  logic [FW-1:0] fill_q;
  logic [31:0] ovl_q, best_q, worst_q, tsum_q;
  logic [15:0] done_q;

  logic [15:0] ring_label [MAX_RECORDS];
  logic [31:0] ring_total [MAX_RECORDS];
  logic [31:0] ring_saved [MAX_RECORDS];

  // latched command
  cmd_e        cmd_q;
  logic [2:0]  okind_q;
  logic [7:0]  sel_q, rsel_q;
  logic [15:0] clabel_q;
  logic [31:0] now_q;

  // sequencer counters and the shared accumulator
  logic [SW:0] i_q, j_q;
  logic [2:0]  k_q;
  logic [31:0] acc_q;
  logic [6:0]  cnt_q;

  logic        res_ok_q;
  logic [7:0]  res_given_q;
  logic [15:0] res_rl_q;
  logic [31:0] res_rt_q, res_rs_q;

  logic accept;
  assign ready_o = (state_q == StIdle);
  assign accept  = valid_i & ready_o;

  logic [SW-1:0] sel_idx;
  logic          sel_ok;
  assign sel_idx = sel_q[SW-1:0];
  assign sel_ok  = ({24'd0, sel_q} < 32'(used_q)) && (run_q[sel_idx] == RunActive);

  logic [31:0] dur;
  assign dur = now_q - start_q[sel_idx];

  logic [SW-1:0] ii, jj;
  assign ii = i_q[SW-1:0];
  assign jj = j_q[SW-1:0];

  logic rd_ok;
  assign rd_ok = ({24'd0, rsel_q} < 32'(fill_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (accept) state_d = StExec;
      StExec: begin
        case (cmd_q)
          CmdScan: state_d = StScan;
          CmdCompleteCyc: state_d = open_q ? StCatSum : StCount;
          default: state_d = StCount;
        endcase
      end
      StScan:   if (32'(i_q) >= 32'(used_q)) state_d = StCount;
      StCatSum: if (32'(k_q) == KindCount - 1) state_d = StFinish;
      StFinish: state_d = StCount;
      StCount:  if (32'(i_q) >= 32'(used_q)) state_d = StOut;
      StOut:    if (ready_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  assign valid_o = (state_q == StOut);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_e'(command_i);
      okind_q  <= op_kind_i;
      sel_q    <= slot_select_i;
      rsel_q   <= record_select_i;
      clabel_q <= cycle_label_i;
      now_q    <= now_ms_i;
    end
    if (state_q == StExec && cmd_q == CmdStartOp && 32'(used_q) < MAX_OPS)
      start_q[used_q[SW-1:0]] <= now_q;
    if (state_q == StFinish) begin
      ring_label[wpos_q] <= cur_label_q;
      ring_total[wpos_q] <= acc_q - saved_q;
      ring_saved[wpos_q] <= saved_q;
    end
    if (state_q == StExec) begin
      res_rl_q <= 16'd0;
      res_rt_q <= 32'd0;
      res_rs_q <= 32'd0;
      if (cmd_q == CmdRead && rd_ok) begin
        res_rl_q <= ring_label[rsel_q[RW-1:0]];
        res_rt_q <= ring_total[rsel_q[RW-1:0]];
        res_rs_q <= ring_saved[rsel_q[RW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int n = 0; n < MAX_OPS; n++) begin
        kind_q[n] <= 3'd0;
        run_q[n]  <= RunIdle;
        mark_q[n] <= 1'b0;
      end
      for (int n = 0; n < KindCount; n++) cat_q[n] <= 32'd0;
      used_q <= '0; saved_q <= 32'd0; cur_label_q <= 16'd0; open_q <= 1'b0;
      wpos_q <= '0; fill_q <= '0; ovl_q <= 32'd0; best_q <= AllOnes;
      worst_q <= 32'd0; tsum_q <= 32'd0; done_q <= 16'd0;
      i_q <= '0; j_q <= '0; k_q <= 3'd0; acc_q <= 32'd0; cnt_q <= 7'd0;
      res_ok_q <= 1'b0; res_given_q <= NoSlot;
    end else begin
      state_q <= state_d;
      case (state_q)
        StExec: begin
          i_q <= '0; j_q <= {{SW{1'b0}}, 1'b1}; k_q <= 3'd0; acc_q <= 32'd0;
          cnt_q <= 7'd0;
          res_ok_q <= 1'b1; res_given_q <= NoSlot;
          case (cmd_q)
            CmdStartOp: begin
              if (32'(used_q) < MAX_OPS) begin
                kind_q[used_q[SW-1:0]] <= okind_q;
                run_q[used_q[SW-1:0]]  <= RunActive;
                mark_q[used_q[SW-1:0]] <= 1'b0;
                res_given_q <= 8'(used_q);
                used_q <= used_q + 1'b1;
              end else res_ok_q <= 1'b0;
            end
            CmdCompleteOp: begin
              if (sel_ok) begin
                run_q[sel_idx] <= RunDone;
                if (open_q && kind_q[sel_idx] < 3'(KindCount))
                  cat_q[kind_q[sel_idx]] <= cat_q[kind_q[sel_idx]] + dur;
                if (mark_q[sel_idx]) begin
                  ovl_q <= ovl_q + dur;
                  if (open_q) saved_q <= saved_q + dur;
                end
              end else res_ok_q <= 1'b0;
            end
            CmdCancelOp: begin
              if (sel_ok) run_q[sel_idx] <= RunCancel;
              else res_ok_q <= 1'b0;
            end
            CmdStartCyc: begin
              if (!open_q) begin
                for (int n = 0; n < KindCount; n++) cat_q[n] <= 32'd0;
                saved_q <= 32'd0; cur_label_q <= clabel_q;
                open_q <= 1'b1; used_q <= '0;
              end else res_ok_q <= 1'b0;
            end
            CmdCompleteCyc: if (!open_q) res_ok_q <= 1'b0;
            CmdClear: begin
              for (int n = 0; n < MAX_OPS; n++) begin
                kind_q[n] <= 3'd0; run_q[n] <= RunIdle; mark_q[n] <= 1'b0;
              end
              for (int n = 0; n < KindCount; n++) cat_q[n] <= 32'd0;
              used_q <= '0; saved_q <= 32'd0; cur_label_q <= 16'd0; open_q <= 1'b0;
              wpos_q <= '0; fill_q <= '0; ovl_q <= 32'd0; best_q <= AllOnes;
              worst_q <= 32'd0; tsum_q <= 32'd0; done_q <= 16'd0;
            end
            CmdRead: res_ok_q <= rd_ok;
            default: ;
          endcase
        end
        StScan: begin
          // walk pairs i<j, one compare per cycle
          if (32'(i_q) < 32'(used_q)) begin
            if (32'(j_q) < 32'(used_q)) begin
              if (run_q[ii] == RunActive && run_q[jj] == RunActive &&
                  pair_allowed(kind_q[ii], kind_q[jj])) begin
                mark_q[ii] <= 1'b1;
                mark_q[jj] <= 1'b1;
              end
              j_q <= j_q + 1'b1;
            end else begin
              i_q <= i_q + 1'b1;
              j_q <= i_q + 2'd2;
            end
          end else i_q <= '0;
        end
        StCatSum: begin
          acc_q <= acc_q + cat_q[k_q];
          k_q <= k_q + 1'b1;
        end
        StFinish: begin
          open_q <= 1'b0;
          wpos_q <= (32'(wpos_q) == MAX_RECORDS - 1) ? '0 : wpos_q + 1'b1;
          if (32'(fill_q) < MAX_RECORDS) fill_q <= fill_q + 1'b1;
          done_q <= done_q + 16'd1;
          tsum_q <= tsum_q + (acc_q - saved_q);
          if ((acc_q - saved_q) < best_q) best_q <= acc_q - saved_q;
          if ((acc_q - saved_q) > worst_q) worst_q <= acc_q - saved_q;
        end
        StCount: begin
          if (32'(i_q) < 32'(used_q)) begin
            if (run_q[ii] == RunActive) cnt_q <= cnt_q + 7'd1;
            i_q <= i_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign ok_o                 = res_ok_q;
  assign slot_given_o         = res_given_q;
  assign record_cycle_label_o = res_rl_q;
  assign record_total_ms_o    = res_rt_q;
  assign record_saved_ms_o    = res_rs_q;
  assign running_count_o      = cnt_q;
  assign record_count_o       = 7'(fill_q);
  assign cycles_done_o        = done_q;
  assign overlap_total_ms_o   = ovl_q;
  assign best_ms_o            = best_q;
  assign worst_ms_o           = worst_q;
  assign cycle_sum_ms_o       = tsum_q;

endmodule

@@ design/oocp_checker.sv @@
// Port-level checker for the profiler, bound to the top level.
module oocp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_o,
  input logic       valid_o,
  input logic       ready_i,
  input logic       ok_o,
  input logic [7:0] slot_given_o,
  input logic [6:0] running_count_o,
  input logic [6:0] record_count_o,
  input logic [31:0] best_ms_o,
  input logic [31:0] worst_ms_o
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ready_o && valid_o)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(ok_o) && $stable(slot_given_o))
    else $error("result changed while stalled");
  a_given_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && slot_given_o != 8'd255 |-> ok_o) else $error("slot without ok");
  a_best_worst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && record_count_o != 7'd0 |-> best_ms_o <= worst_ms_o)
    else $error("best above worst");
endmodule

bind op_overlap_cycle_profiler_unit oocp_checker u_oocp_checker (.*);
